// ===== hdl/trsf_pkg.sv =====
// package for the tilemap row scan filter
// holds map geometry, register indexes, tile field positions and the sequencer state type
// no dependencies
package trsf_pkg;

    // map geometry: the layer is square, MAP_SIDE tiles each way
    localparam int MAP_SIDE    = 64;
    localparam int MAP_BITS    = $clog2(MAP_SIDE);
    localparam int STORE_DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

    // default visible window
    localparam int DEF_VISIBLE_COLUMNS = 41;
    localparam int DEF_VISIBLE_ROWS    = 31;

    // configuration register indexes
    localparam logic [1:0] CFG_SCROLL_X   = 2'd0;
    localparam logic [1:0] CFG_SCROLL_Y   = 2'd1;
    localparam logic [1:0] CFG_VERT_ADJ   = 2'd2;

    // scroll and tile fields
    localparam int SCROLL_BITS = 9;
    localparam logic [SCROLL_BITS-1:0] VADJ_LINES = 9'd16;
    localparam int HIDE_BIT    = 15;

    // input mode codes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_SCAN = 1'b1;

    // scan sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FLUSH
    } t_state;

endpackage

// ===== hdl/tilemap_row_scan_filter_core.sv =====
// top level of the tilemap row scan filter: tilemap memory, scan sequencer and result stage
// depends on trsf_pkg
//
// A load (mode 0) writes one 32-bit map entry at the accepting edge; busy stays low.
// A scan (mode 1) of a visible row keeps busy high from its transfer through the scan,
// drain and flush states: in scan the single read port of the tilemap memory walks one
// map cell per cycle, drain takes the last read and flush sends the held tile with last
// set. The last result of a row shows in the first cycle after busy falls. A scan of a
// row at or beyond VISIBLE_ROWS leaves busy low and gives no results. Each result is
// shown for one cycle under o_strobe and cannot be held off by the receiver; results
// of a row come out in column order, at most one per cycle.
// The memory has no reset or clearing pass: a row must only be scanned after every cell it
// touches was loaded. Configuration writes are always ready and should only be made idle.
module tilemap_row_scan_filter_core #(
    parameter int VISIBLE_COLUMNS = trsf_pkg::DEF_VISIBLE_COLUMNS,
    parameter int VISIBLE_ROWS    = trsf_pkg::DEF_VISIBLE_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item command
    input  logic               start,
    output logic               busy,
    input  logic               i_mode,
    input  logic [11:0]        i_entry_index,
    input  logic [15:0]        i_entry_attrib,
    input  logic [15:0]        i_entry_number,
    input  logic [4:0]         i_row_index,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    // results
    output logic               o_strobe,
    output logic [3:0]         o_priority_res,
    output logic [15:0]        o_tile_attrib,
    output logic [14:0]        o_tile_number,
    output logic signed [9:0]  o_screen_x,
    output logic signed [8:0]  o_screen_y,
    output logic               o_last
);
    import trsf_pkg::*;

    localparam logic [MAP_BITS-1:0] LAST_COL = MAP_BITS'(VISIBLE_COLUMNS - 1);
    localparam logic [MAP_BITS:0]   ROW_LIM  = (MAP_BITS + 1)'(VISIBLE_ROWS);

    // configuration registers
    logic [SCROLL_BITS-1:0] r_scroll_x;
    logic [SCROLL_BITS-1:0] r_scroll_y;
    logic                   r_vert_adj;

    // sequencer
    t_state              r_state, n_state;
    logic [MAP_BITS-1:0] r_col, n_col;
    logic [MAP_BITS-1:0] r_map_col, n_map_col;
    logic [MAP_BITS-1:0] r_map_row, n_map_row;
    logic [2:0]          r_fine_x, n_fine_x;
    logic [8:0]          r_screen_y, n_screen_y;
    logic                n_rd_valid;

    // read stage
    logic                r_rd_valid;
    logic [MAP_BITS-1:0] r_rd_col;
    logic [31:0]         r_rd_data;

    // held tile waiting to learn whether it is the last
    logic                r_pend_valid;
    logic [15:0]         r_pend_attrib;
    logic [14:0]         r_pend_number;
    logic [9:0]          r_pend_x;

    // result registers
    logic                r_strobe;
    logic [15:0]         r_out_attrib;
    logic [14:0]         r_out_number;
    logic [9:0]          r_out_x;
    logic [8:0]          r_out_y;
    logic                r_out_last;

    logic                    accept;
    logic                    cfg_we;
    logic                    map_we;
    logic [ADDR_BITS-1:0]    rd_addr;
    logic [SCROLL_BITS-1:0]  eff_y;
    logic [8:0]              row_y;
    logic                    row_ok;
    logic                    qual;
    logic [9:0]              rd_x;

    // tilemap memory: attribute in the high half, number in the low half
    logic [31:0] mem [STORE_DEPTH];

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign map_we      = accept && (i_mode == MODE_LOAD);
    assign rd_addr     = {r_map_row, r_map_col};

    // memory write on load transfer, registered read every cycle
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            mem[i_entry_index[ADDR_BITS-1:0]] <= {i_entry_attrib, i_entry_number};
        end
        r_rd_data <= mem[rd_addr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_x <= '0;
            r_scroll_y <= '0;
            r_vert_adj <= 1'b0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_SCROLL_X: r_scroll_x <= i_cfg_data;
                CFG_SCROLL_Y: r_scroll_y <= i_cfg_data;
                CFG_VERT_ADJ: r_vert_adj <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // scan setup values
    assign eff_y  = r_vert_adj ? (r_scroll_y + VADJ_LINES) : r_scroll_y;
    assign row_y  = {1'b0, i_row_index, 3'b000} - {6'd0, eff_y[2:0]};
    assign row_ok = {2'b00, i_row_index} < ROW_LIM;

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= n_rd_valid;
        end
    end

    // sequencer counters and row setup
    always_ff @(posedge i_clk) begin
        r_col      <= n_col;
        r_map_col  <= n_map_col;
        r_map_row  <= n_map_row;
        r_fine_x   <= n_fine_x;
        r_screen_y <= n_screen_y;
        r_rd_col   <= r_col;
    end

    // next state: one map read issued per scan cycle through the map column counter
    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_map_col  = r_map_col;
        n_map_row  = r_map_row;
        n_fine_x   = r_fine_x;
        n_screen_y = r_screen_y;
        n_rd_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_mode == MODE_SCAN) && row_ok) begin
                    n_state    = ST_SCAN;
                    n_col      = '0;
                    n_map_col  = r_scroll_x[SCROLL_BITS-1:3];
                    n_map_row  = eff_y[SCROLL_BITS-1:3] + {1'b0, i_row_index};
                    n_fine_x   = r_scroll_x[2:0];
                    n_screen_y = row_y;
                end
            end
            ST_SCAN: begin
                n_rd_valid = 1'b1;
                n_col      = r_col + 1'b1;
                n_map_col  = r_map_col + 1'b1;
                if (r_col == LAST_COL) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // tile filter on the read data
    assign qual = r_rd_valid && !r_rd_data[HIDE_BIT] && (r_rd_data[31:28] != 4'd0);
    assign rd_x = {1'b0, r_rd_col, 3'b000} - {7'd0, r_fine_x};

    // held tile and result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (qual) begin
                r_pend_valid <= 1'b1;
                r_strobe     <= r_pend_valid;
            end else if ((r_state == ST_FLUSH) && r_pend_valid) begin
                r_pend_valid <= 1'b0;
                r_strobe     <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (qual) begin
            r_pend_attrib <= r_rd_data[31:16];
            r_pend_number <= r_rd_data[14:0];
            r_pend_x      <= rd_x;
        end
        // a held tile goes out as last only from the flush cycle
        if (qual || (r_state == ST_FLUSH)) begin
            r_out_attrib <= r_pend_attrib;
            r_out_number <= r_pend_number;
            r_out_x      <= r_pend_x;
            r_out_y      <= r_screen_y;
            r_out_last   <= !qual;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_priority_res = r_out_attrib[15:12];
    assign o_tile_attrib  = r_out_attrib;
    assign o_tile_number  = r_out_number;
    assign o_screen_x     = r_out_x;
    assign o_screen_y     = r_out_y;
    assign o_last         = r_out_last;

    // results only come from a scan in progress
    a_strobe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) != ST_IDLE))
        else $error("result strobe without a scan in progress");

    // the last tile of a row closes the burst
    a_last_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result strobe right after the last tile of a row");

    // the scan stops issuing reads after the final visible column
    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && (r_col == LAST_COL)) |=> (r_state == ST_DRAIN))
        else $error("scan ran past the final visible column");

    // no tile is left held once the block is idle
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("held tile left behind after the scan");

endmodule
